// ----- hdl/pursuit_target_index_defines.svh -----
// Assertion macros shared by the pursuit target index RTL.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef PURSUIT_TARGET_INDEX_DEFINES_SVH
`define PURSUIT_TARGET_INDEX_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PTI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define PTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pti_pkg.sv -----
// Package for the pursuit target index block: request and status codes, field widths.
// Depends on nothing; used by the interfaces and the top level.
package pti_pkg;

	localparam int unsigned CoordW = 31;
	localparam int unsigned SegW   = 32;
	localparam int unsigned GainW  = 24;
	localparam int unsigned BaseW  = 31;
	localparam int unsigned IdxW   = 10;
	localparam int unsigned CfgW   = 31;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	localparam logic [0:0] CFG_GAIN = 1'b0;
	localparam logic [0:0] CFG_BASE = 1'b1;

	localparam logic [GainW-1:0] GainReset = 24'd6554;
	localparam logic [BaseW-1:0] BaseReset = 31'd3276800;

endpackage

// ----- hdl/pti_req_if.sv -----
// Channel interfaces of the pursuit target index block: request and result.
// Depends on pti_pkg for field widths.
interface pti_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic signed [pti_pkg::CoordW-1:0] point_x;
	logic signed [pti_pkg::CoordW-1:0] point_y;
	logic signed [pti_pkg::CoordW-1:0] pos_x;
	logic signed [pti_pkg::CoordW-1:0] pos_y;
	logic signed [pti_pkg::CoordW-1:0] speed_fwd;
	modport source (output valid, req_type, point_x, point_y, pos_x, pos_y, speed_fwd,
		input ready);
	modport sink (input valid, req_type, point_x, point_y, pos_x, pos_y, speed_fwd,
		output ready);
endinterface

interface pti_res_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [pti_pkg::IdxW-1:0] tgt_index;
	modport source (output valid, status, tgt_index, input ready);
	modport sink (input valid, status, tgt_index, output ready);
endinterface

// ----- hdl/pursuit_target_index.sv -----
// Pursuit target index: path store plus nearest-point and look-ahead walk sequencer.
// Steps from acceptance to result valid: clear, unused code, full or empty go straight to S_OUT;
// first append stores at once; other appends read, square, load, take 32 root steps and store;
// query scans every stored point (read, squares, compare), then walks segments (read, add) past
// the nearest. One transaction at a time; ready is low while busy or a result waits.
// Reset: arst_n clears sequencer, point count, config, result and index regs, not path memories.
`include "pursuit_target_index_defines.svh"

module pursuit_target_index #(
	parameter int unsigned PATH_DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [pti_pkg::CfgW-1:0] cfg_wdata,
	pti_req_if.sink   req,
	pti_res_if.source res
);

	// Address width for the memories and a count width that can hold PATH_DEPTH itself.
	localparam int unsigned AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
	localparam int unsigned CW = $clog2(PATH_DEPTH + 1);
	localparam int unsigned CoordW = pti_pkg::CoordW;
	localparam int unsigned SegW = pti_pkg::SegW;
	localparam logic [CW-1:0] DepthC = CW'(PATH_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_AP_RD, S_AP_SQX, S_AP_SQY, S_AP_ROOT, S_AP_WR,
		S_Q_RD, S_Q_SQX, S_Q_SQY, S_Q_CMP, S_Q_LF, S_W_RD, S_W_ADD, S_OUT
	} state_t;

	state_t state_q;

	// Path memories: written at one address, read at one address, registered read data.
	logic signed [CoordW-1:0] mem_x [PATH_DEPTH];
	logic signed [CoordW-1:0] mem_y [PATH_DEPTH];
	logic [SegW-1:0] mem_s [PATH_DEPTH];
	logic signed [CoordW-1:0] rd_x_q, rd_y_q;
	logic [SegW-1:0] rd_s_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_en;
	logic [SegW-1:0] wr_seg;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q, best_q;
	logic [pti_pkg::GainW-1:0] gain_q;
	logic [pti_pkg::BaseW-1:0] base_q;

	// Latched item.
	logic signed [CoordW-1:0] ax_q, ay_q, sp_q;

	// Shared datapath: one 32x32 multiplier, one adder and the root stepper.
	logic [31:0] dx_abs_q, dy_abs_q;
	logic [63:0] sq_q, dist_sum, best_d_q;
	logic [63:0] rem_q, root_q;
	logic [5:0] step_q;
	logic signed [64:0] lf_q, acc_q;
	logic [1:0] status_q;
	logic [pti_pkg::IdxW-1:0] tgt_q;
	logic res_valid_q;
	logic res_free;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic signed [32:0] dxs, dys;
	logic signed [55:0] gprod;
	logic [63:0] sq_bit;
	logic [63:0] trial;

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
	assign gprod = $signed({1'b0, gain_q}) * sp_q;
	assign dxs = 33'(ax_q) - 33'(rd_x_q);
	assign dys = 33'(ay_q) - 33'(rd_y_q);
	assign dist_sum = sq_q + mul_p;
	assign sq_bit = 64'd1 << {step_q, 1'b0};
	assign trial = root_q + sq_bit;

	always_comb begin
		mul_a = dx_abs_q;
		mul_b = dx_abs_q;
		if (state_q == S_AP_SQY || state_q == S_Q_SQY) begin
			mul_a = dy_abs_q;
			mul_b = dy_abs_q;
		end
	end

	assign res_free = !res_valid_q || res.ready;
	assign req.ready = (state_q == S_IDLE) && !res_valid_q;
	assign res.valid = res_valid_q;
	assign res.status = status_q;
	assign res.tgt_index = tgt_q;

	always_comb begin
		rd_addr = idx_q[AW-1:0];
		wr_addr = count_q[AW-1:0];
		wr_en = (state_q == S_AP_WR);
		wr_seg = (count_q == '0) ? '0 : root_q[SegW-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= ax_q;
			mem_y[wr_addr] <= ay_q;
			mem_s[wr_addr] <= wr_seg;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
		rd_s_q <= mem_s[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			gain_q <= pti_pkg::GainReset;
			base_q <= pti_pkg::BaseReset;
			res_valid_q <= 1'b0;
			status_q <= pti_pkg::ST_OK;
			tgt_q <= '0;
			idx_q <= '0;
			best_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pti_pkg::CFG_GAIN: gain_q <= cfg_wdata[pti_pkg::GainW-1:0];
					pti_pkg::CFG_BASE: base_q <= cfg_wdata[pti_pkg::BaseW-1:0];
					default: ;
				endcase
			end
			// The result register is loaded from S_OUT and emptied by the sink.
			if (state_q == S_OUT && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						sp_q <= req.speed_fwd;
						tgt_q <= '0;
						case (req.req_type)
							pti_pkg::REQ_CLEAR: begin
								count_q <= '0;
								status_q <= pti_pkg::ST_OK;
								state_q <= S_OUT;
							end
							pti_pkg::REQ_APPEND: begin
								ax_q <= req.point_x;
								ay_q <= req.point_y;
								if (count_q >= DepthC) begin
									status_q <= pti_pkg::ST_FULL;
									state_q <= S_OUT;
								end else begin
									status_q <= pti_pkg::ST_OK;
									idx_q <= (count_q == '0) ? '0 : count_q - 1'b1;
									// The first point has no segment; store it at once.
									state_q <= (count_q == '0) ? S_AP_WR : S_AP_RD;
								end
							end
							pti_pkg::REQ_QUERY: begin
								ax_q <= req.pos_x;
								ay_q <= req.pos_y;
								if (count_q == '0) begin
									status_q <= pti_pkg::ST_EMPTY;
									state_q <= S_OUT;
								end else begin
									status_q <= pti_pkg::ST_OK;
									idx_q <= '0;
									best_q <= '0;
									state_q <= S_Q_RD;
								end
							end
							default: begin
								status_q <= pti_pkg::ST_OK;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_AP_RD, S_Q_RD: begin
					// Memory read lands this cycle; take absolute differences next.
					state_q <= (state_q == S_AP_RD) ? S_AP_SQX : S_Q_SQX;
				end
				S_AP_SQX, S_Q_SQX: begin
					dx_abs_q <= 32'(dxs[32] ? -dxs : dxs);
					dy_abs_q <= 32'(dys[32] ? -dys : dys);
					state_q <= (state_q == S_AP_SQX) ? S_AP_SQY : S_Q_SQY;
				end
				S_AP_SQY, S_Q_SQY: begin
					// Multiplier here squares dy; next cycle it squares dx.
					sq_q <= mul_p;
					if (state_q == S_AP_SQY) begin
						state_q <= S_AP_ROOT;
						step_q <= 6'd32;
						root_q <= '0;
					end else begin
						state_q <= S_Q_CMP;
					end
				end
				S_AP_ROOT: begin
					// Bit-pair restoring square root: a load step, then one result
					// bit per cycle from bit weight 4^31 down to 4^0.
					if (step_q == 6'd32) begin
						rem_q <= dist_sum;
						root_q <= '0;
						step_q <= 6'd31;
					end else begin
						if (rem_q >= trial) begin
							rem_q <= rem_q - trial;
							root_q <= (root_q >> 1) + sq_bit;
						end else begin
							root_q <= root_q >> 1;
						end
						if (step_q == 6'd0) begin
							state_q <= S_AP_WR;
						end
						step_q <= step_q - 1'b1;
					end
				end
				S_AP_WR: begin
					count_q <= count_q + 1'b1;
					state_q <= S_OUT;
				end
				S_Q_CMP: begin
					if (idx_q == '0 || dist_sum < best_d_q) begin
						best_d_q <= dist_sum;
						best_q <= idx_q;
					end
					if (idx_q + 1'b1 >= count_q) begin
						state_q <= S_Q_LF;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_Q_RD;
					end
				end
				S_Q_LF: begin
					// Arithmetic shift floors toward minus infinity.
					lf_q <= 65'(gprod >>> 16) + 65'(base_q);
					acc_q <= '0;
					idx_q <= best_q + 1'b1;
					state_q <= S_W_RD;
				end
				S_W_RD: begin
					if (lf_q > acc_q && idx_q < count_q) begin
						state_q <= S_W_ADD;
					end else begin
						tgt_q <= pti_pkg::IdxW'(best_q);
						state_q <= S_OUT;
					end
				end
				S_W_ADD: begin
					acc_q <= acc_q + 65'(rd_s_q);
					best_q <= idx_q;
					idx_q <= idx_q + 1'b1;
					state_q <= S_W_RD;
				end
				S_OUT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PTI_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= DepthC, "point count over depth")
	`PTI_ASSERT_IMPL(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !req.ready, "ready while busy")
	`PTI_ASSERT_NEXT(a_out_valid, clk, arst_n, state_q == S_OUT && res_free, res_valid_q, "result lost")

endmodule
